>>> design/kss_pkg.sv
// package for the k-th smallest selector: shared types and constants
// no dependencies
`default_nettype none
package kss_pkg;
    localparam int MAX_ELEMENTS_DEF = 256;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PIVOT_RD,
        ST_PIVOT_LAT,
        ST_SCAN,
        ST_CHECK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic store;      // write incoming value at fill count
        logic clr_count;  // empty the store after selection
        logic pivot_rd;   // drive read address with candidate index
        logic pivot_lat;  // capture candidate value, clear tallies
        logic scan_rd;    // drive read address with scan index
        logic scan_acc;   // tally the data from the previous scan read
        logic next_cand;  // advance candidate index
        logic out_load;   // load result register
        logic out_bad;    // result is an error
    } cmd_t;

    typedef struct packed {
        logic scan_done;  // scan index reached count
        logic hit;        // candidate sits at the wanted rank
        logic cand_last;  // candidate index is the final element
        logic bad;        // rank not below count
    } sts_t;
endpackage
`default_nettype wire

>>> design/kss_datapath.sv
// datapath of the selector: element store, count, tallies, result register
// depends on kss_pkg
`default_nettype none
module kss_datapath #(
    parameter int MAX_ELEMENTS = kss_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [31:0]        value,
    input  wire logic [7:0]         rank,
    input  wire kss_pkg::cmd_t      cmd,
    output kss_pkg::sts_t           sts,
    output logic [31:0]             selected
);
    import kss_pkg::*;
    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    // rank compares run wide enough for both the count and the full rank
    localparam int RW = (CW > 8) ? CW : 8;

    logic [31:0]   mem [MAX_ELEMENTS];
    logic [31:0]   rd_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] cand_reg;
    logic [CW-1:0] scan_reg;
    logic [CW-1:0] below_reg;
    logic [CW-1:0] notab_reg;
    logic [7:0]    rank_reg;
    logic [31:0]   pivot_reg;
    logic [31:0]   sel_reg;
    logic [AW-1:0] rd_addr;
    logic          lt;
    logic          eq;

    assign rd_addr = cmd.pivot_rd ? cand_reg[AW-1:0] : scan_reg[AW-1:0];
    assign lt = $signed(rd_reg) < $signed(pivot_reg);
    assign eq = rd_reg == pivot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store && count_reg < CW'(MAX_ELEMENTS))
            mem[count_reg[AW-1:0]] <= value;
        rd_reg <= mem[rd_addr];
        if (cmd.store)
            rank_reg <= rank;
        if (cmd.pivot_lat)
            pivot_reg <= rd_reg;
        if (cmd.out_load)
            sel_reg <= cmd.out_bad ? 32'd0 : pivot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cand_reg  <= '0;
            scan_reg  <= '0;
            below_reg <= '0;
            notab_reg <= '0;
        end
        else
        begin
            if (cmd.clr_count)
            begin
                count_reg <= '0;
                cand_reg  <= '0;
            end
            else if (cmd.store && count_reg < CW'(MAX_ELEMENTS))
                count_reg <= count_reg + 1'b1;
            if (cmd.next_cand)
                cand_reg <= cand_reg + 1'b1;
            if (cmd.pivot_lat)
            begin
                scan_reg  <= '0;
                below_reg <= '0;
                notab_reg <= '0;
            end
            else
            begin
                if (cmd.scan_rd)
                    scan_reg <= scan_reg + 1'b1;
                if (cmd.scan_acc)
                begin
                    below_reg <= below_reg + CW'(lt);
                    notab_reg <= notab_reg + CW'(lt | eq);
                end
            end
        end
    end

    assign sts.scan_done = scan_reg == count_reg;
    assign sts.hit       = RW'(below_reg) <= RW'(rank_reg) && RW'(rank_reg) < RW'(notab_reg);
    assign sts.cand_last = cand_reg + 1'b1 >= count_reg;
    assign sts.bad       = count_reg == '0 || RW'(rank_reg) >= RW'(count_reg);
    assign selected      = sel_reg;
endmodule
`default_nettype wire

>>> design/kss_ctrl.sv
// controller of the selector: load, candidate scan and output handshake
// depends on kss_pkg
`default_nettype none
module kss_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic          in_last,
    input  wire logic          out_taken,
    input  wire kss_pkg::sts_t sts,
    output kss_pkg::cmd_t      cmd,
    output logic               in_ready,
    output logic               out_valid,
    output logic               bad_rank
);
    import kss_pkg::*;
    state_t state_reg, state_next;
    logic   acc_reg, acc_next;
    logic   bad_reg, bad_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            acc_reg   <= 1'b0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            bad_reg   <= bad_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = 1'b0;
        bad_next   = bad_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready  = 1'b1;
                cmd.store = in_fire;
                if (in_fire && in_last)
                    state_next = ST_PIVOT_RD;
            end
            ST_PIVOT_RD:
            begin
                if (sts.bad)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_bad  = 1'b1;
                    bad_next     = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.pivot_rd = 1'b1;
                    state_next   = ST_PIVOT_LAT;
                end
            end
            ST_PIVOT_LAT:
            begin
                cmd.pivot_lat = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                // read one element per cycle, tally it the cycle after
                cmd.scan_acc = acc_reg;
                if (sts.scan_done)
                    state_next = acc_reg ? ST_SCAN : ST_CHECK;
                else
                begin
                    cmd.scan_rd = 1'b1;
                    acc_next    = 1'b1;
                end
                if (sts.scan_done && acc_reg)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.hit || sts.cand_last)
                begin
                    cmd.out_load = 1'b1;
                    bad_next     = 1'b0;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.next_cand = 1'b1;
                    state_next    = ST_PIVOT_RD;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_taken)
                begin
                    cmd.clr_count = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign bad_rank = bad_reg;
endmodule
`default_nettype wire

>>> design/kth_smallest_select_core.sv
// k-th smallest selector, top level: ties controller and datapath together
// depends on kss_pkg, kss_ctrl, kss_datapath
//
// usage: send a set of signed 32-bit values as requests on the s_axis
// channel; the request with s_axis_tlast high ends the set and carries the
// zero-based rank in s_axis_tuser. one result leaves on m_axis: the value at
// that rank in ascending order, or zero with the error bit set when the rank
// is not below the count. values past MAX_ELEMENTS are dropped.
// during loading a request is taken whenever one is offered. selection tries
// each stored element in turn as candidate, counting elements below and not
// above it with one comparator over the single store read port; then the
// result waits in its register until m_axis_tready; no new set is taken
// meanwhile. reset empties the store and clears the handshake state.
`default_nettype none
module kth_smallest_select_core #(
    parameter int MAX_ELEMENTS = kss_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // value
    input  wire logic [7:0]  s_axis_tuser,   // rank
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // selected
    output logic             m_axis_tuser    // bad_rank
);
    import kss_pkg::*;
    cmd_t cmd;
    sts_t sts;

    kss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid & s_axis_tready),
        .in_last   (s_axis_tlast),
        .out_taken (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .bad_rank  (m_axis_tuser)
    );

    kss_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (s_axis_tdata),
        .rank     (s_axis_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .selected (m_axis_tdata)
    );
endmodule
`default_nettype wire

>>> verif/kss_checker.sv
// checker for the k-th smallest selector: watches both stream channels,
// predicts the selected value per set and compares; depends on nothing else
module kss_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic [7:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,
    input  wire logic        m_axis_tuser,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 256;

    typedef struct packed {
        logic signed [31:0] selected;
        logic               bad_rank;
    } selection_t;

    logic signed [31:0] held_values [STORE_DEPTH];
    int unsigned        held_count;
    selection_t         selections_due [$];

    function automatic selection_t select_rank(int unsigned n, int unsigned k);
        selection_t r;
        int unsigned below;
        int unsigned not_above;
        r.selected = '0;
        r.bad_rank = 1'b0;
        if (n == 0 || k >= n)
        begin
            r.bad_rank = 1'b1;
            return r;
        end
        for (int a = 0; a < n; a++)
        begin
            below = 0;
            not_above = 0;
            for (int b = 0; b < n; b++)
            begin
                if (held_values[b] < held_values[a])
                    below++;
                if (held_values[b] <= held_values[a])
                    not_above++;
            end
            if (below <= k && k < not_above)
            begin
                r.selected = held_values[a];
                return r;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    assign pending = selections_due.size();

    initial
    begin
        fail_count = 0;
        held_count = 0;
    end

    always @(posedge clk)
    begin
        selection_t due;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (held_count < STORE_DEPTH)
                begin
                    held_values[held_count] = s_axis_tdata;
                    held_count++;
                end
                if (s_axis_tlast)
                begin
                    selections_due.push_back(select_rank(held_count, s_axis_tuser));
                    held_count = 0;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (selections_due.size() == 0)
                    report_mismatch("result with none expected");
                else
                begin
                    due = selections_due.pop_front();
                    if (m_axis_tdata !== due.selected)
                        report_mismatch($sformatf("selected %0d, want %0d",
                            $signed(m_axis_tdata), due.selected));
                    if (m_axis_tuser !== due.bad_rank)
                        report_mismatch($sformatf("bad_rank %0b, want %0b",
                            m_axis_tuser, due.bad_rank));
                end
            end
        end
    end
endmodule

>>> verif/tb_kth_smallest_select_core.sv
// testbench top for the k-th smallest selector: drives sets of values,
// stalls both channels, gives the verdict; depends on kth_smallest_select_core, kss_checker
module tb_kth_smallest_select_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // value
    logic [7:0]  s_axis_tuser = '0;  // rank
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // selected
    logic        m_axis_tuser;       // bad_rank
    int          fail_count;
    int          pending;
    int          sent_requests = 0;
    bit          calm = 1'b0;
    bit          hold_sink = 1'b0;
    longint      cycle_count = 0;

    localparam int TOTAL_REQUESTS = 1850;
    localparam longint CYCLE_LIMIT = 6000000;

    kth_smallest_select_core dut (.*);

    kss_checker checker_i (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_kth_smallest_select_core: FAIL");
            $finish;
        end
    end

    // receiver: random short stalls, one long hold while requests keep coming
    initial
    begin
        int gap;
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_sink = 1'b0;
            end
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // tvalid stays up after a request until the next one or an idle replaces it
    task automatic send_value(input logic [31:0] v, input logic [7:0] k, input logic lst);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        s_axis_tuser <= k;
        s_axis_tlast <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        sent_requests++;
    endtask

    function automatic logic [31:0] pick_value(input int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 3) - 2;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int n, input logic [7:0] k, input int mode);
        for (int i = 0; i < n; i++)
            send_value(mode == 4 ? pick_value($urandom_range(0, 3)) : pick_value(mode),
                       k, i == n - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    initial
    begin
        int n;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: single element, rank out of range, extremes, duplicates
        send_set(1, 8'd0, 0);
        send_set(1, 8'd1, 1);
        send_set(3, 8'd2, 4);
        send_set(4, 8'd255, 2);
        send_set(5, 8'd3, 2);
        send_set(2, 8'd0, 1);
        wait_drained();
        // store overflow: 260 values into a 256 deep store, rank 255
        send_set(260, 8'd255, 4);
        wait_drained();
        // long receiver hold: the result waits and the next set stalls behind it
        hold_sink = 1'b1;
        send_set(8, 8'd7, 3);
        send_set(6, 8'd2, 3);
        wait_drained();
        while (sent_requests < TOTAL_REQUESTS)
        begin
            if (sent_requests > TOTAL_REQUESTS - 200)
                calm = 1'b1;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
            send_set(n, ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, n - 1)),
                     ($urandom_range(0, 3) == 0) ? 4 : 3);
        end
        wait_drained();
        repeat (2000) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_kth_smallest_select_core: PASS");
        else
            $display("tb_kth_smallest_select_core: FAIL");
        $finish;
    end
endmodule
